FILE: src/pirb_pkg.sv
// ----------------------------------------------------------------------------
// pirb_pkg
// Shared types and codes of the per-client input replay buffer.
// ----------------------------------------------------------------------------
package pirb_pkg;

  localparam logic [1:0] ACT_PUSH   = 2'd0;
  localparam logic [1:0] ACT_REPLAY = 2'd1;
  localparam logic [1:0] ACT_ACK    = 2'd2;
  localparam logic [1:0] ACT_PRUNE  = 2'd3;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_NOT_INCR  = 3'd2;
  localparam logic [2:0] ST_TOO_OLD   = 3'd3;
  localparam logic [2:0] ST_TOO_AHEAD = 3'd4;
  localparam logic [2:0] ST_ENTRY     = 3'd5;
  localparam logic [2:0] ST_EMPTY     = 3'd6;

  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_LEAD   = 2'd1;
  localparam logic [1:0] REG_CAP    = 2'd2;

  localparam int CMD_W = 128;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] ctime;
    logic [31:0] stime;
    logic [31:0] payload;
  } cmd_t;

endpackage

FILE: src/pirb_ram.sv
// ----------------------------------------------------------------------------
// pirb_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pirb_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/per_client_input_replay_buffer_top.sv
// ----------------------------------------------------------------------------
// per_client_input_replay_buffer_top
// Per-client ring queues of commands with push checks, replay, ack and prune.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Busy then stays high
// while the request is worked on, and the last result is strobed on done
// (last_result marks it) in the cycle in which busy falls. Results cannot
// be held off. A push to a non-empty queue is checked for order and age, then
// for being too far ahead; a push that passes is written and the queue is then
// trimmed one command at a time to the capacity. Acknowledge and prune drop
// commands one at a time; replay reads each stored command of the client in
// turn, and prune visits every client queue from client 1 on. Each command is
// read through the single read port of the command memory and checked on the
// shared 33-bit compare unit.
module per_client_input_replay_buffer_top #(
  parameter int NUM_CLIENTS = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [3:0]  client_id,
  input  logic [31:0] seq_number,
  input  logic [31:0] client_time_ms,
  input  logic [31:0] server_time_ms,
  input  logic [31:0] payload_word,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [2:0]  status,
  output logic [3:0]  out_client_id,
  output logic [31:0] out_sequence,
  output logic [31:0] out_client_time_ms,
  output logic [31:0] out_server_time_ms,
  output logic [31:0] out_payload,
  output logic        last_result
);
  import pirb_pkg::*;

  localparam int CW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = CW + QW;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHK1  = 9'b000000010,
    S_CHK2  = 9'b000000100,
    S_WRITE = 9'b000001000,
    S_TRIM  = 9'b000010000,
    S_RD    = 9'b000100000,
    S_EVAL  = 9'b001000000,
    S_NEXTC = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic [31:0] hist_win, lead_lim;
  logic [4:0]  cap;

  logic [1:0]  act;
  logic [CW-1:0] cid;
  logic [3:0]  cid_raw;
  logic        cid_ok;
  logic [31:0] rseq, rctime, rstime, rpay;

  logic [QW-1:0] head [NUM_CLIENTS];
  logic [NW-1:0] cnt  [NUM_CLIENTS];
  logic [31:0]   nseq [NUM_CLIENTS];
  logic [31:0]   ntim [NUM_CLIENTS];

  logic [NW-1:0] idx;
  logic          found;
  logic [2:0]    res_st;
  cmd_t          held;

  // shared compare unit: a + b < c on 33 bits
  logic [31:0] cmp_a, cmp_b, cmp_c;
  logic        cmp_lt;
  assign cmp_lt = ({1'b0, cmp_a} + {1'b0, cmp_b}) < {1'b0, cmp_c};

  // memory
  logic          mwe;
  logic [AW-1:0] mwaddr, mraddr;
  cmd_t          mwdata, mrdata;
  logic [CMD_W-1:0] mrraw;
  assign mrdata = cmd_t'(mrraw);

  pirb_ram #(.WIDTH(CMD_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(mwe), .waddr(mwaddr), .wdata(mwdata),
    .raddr(mraddr), .rdata(mrraw)
  );

  logic [QW-1:0] cur_head;
  logic [NW-1:0] cur_cnt;
  logic [QW-1:0] rd_slot, wr_slot;
  logic [NW-1:0] eff_cap;
  assign cur_head = head[cid];
  assign cur_cnt  = cnt[cid];
  assign eff_cap  = (32'(cap) > QUEUE_DEPTH) ? NW'(QUEUE_DEPTH) : NW'(cap);

  function automatic logic [QW-1:0] wrap_add(input logic [QW-1:0] h,
                                             input logic [NW-1:0] n);
    logic [NW:0] s;
    s = (NW+1)'(h) + (NW+1)'(n);
    if (s >= (NW+1)'(QUEUE_DEPTH)) s = s - (NW+1)'(QUEUE_DEPTH);
    return QW'(s);
  endfunction

  assign rd_slot = wrap_add(cur_head, (act == ACT_REPLAY) ? idx : '0);
  assign wr_slot = wrap_add(cur_head, cur_cnt);
  assign mraddr  = {cid, rd_slot};
  assign mwaddr  = {cid, wr_slot};
  assign mwdata  = '{seq: rseq, ctime: rctime, stime: rstime, payload: rpay};
  assign mwe     = (state == S_WRITE);

  // compare operand selection
  always_comb begin
    cmp_a = '0; cmp_b = '0; cmp_c = '0;
    case (state)
      S_CHK1: begin
        cmp_a = rctime; cmp_b = hist_win; cmp_c = ntim[cid];
      end
      S_CHK2: begin
        cmp_a = ntim[cid]; cmp_b = lead_lim; cmp_c = rctime;
      end
      S_EVAL: begin
        if (act == ACT_PRUNE) begin
          cmp_a = mrdata.stime; cmp_b = hist_win; cmp_c = rstime;
        end else if (act == ACT_ACK) begin
          cmp_a = rseq; cmp_b = 32'd0; cmp_c = mrdata.seq;
        end else begin
          cmp_a = mrdata.seq; cmp_b = 32'd0; cmp_c = rseq;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      hist_win <= 32'd1000;
      lead_lim <= 32'd250;
      cap      <= 5'd16;
      done     <= 1'b0;
      found    <= 1'b0;
      cid      <= '0;
      for (int i = 0; i < NUM_CLIENTS; i++) begin
        head[i] <= '0;
        cnt[i]  <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW: hist_win <= cfg_data;
          REG_LEAD:   lead_lim <= cfg_data;
          REG_CAP:    cap      <= cfg_data[4:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            act     <= action;
            cid_raw <= client_id;
            cid     <= (action == ACT_PRUNE) ? CW'(1) : CW'(client_id);
            cid_ok  <= (client_id != 4'd0) && (32'(client_id) < NUM_CLIENTS);
            rseq <= seq_number; rctime <= client_time_ms;
            rstime <= server_time_ms; rpay <= payload_word;
            idx <= '0; found <= 1'b0;
            state <= S_CHK1;
          end
        end
        S_CHK1: begin
          // dispatch and first push check
          res_st <= ST_DONE;
          if (act == ACT_PRUNE) begin
            state <= S_RD;
          end else if (!cid_ok) begin
            res_st <= (act == ACT_PUSH) ? ST_INVALID :
                      (act == ACT_REPLAY) ? ST_EMPTY : ST_DONE;
            state <= S_OUT;
          end else if (act != ACT_PUSH) begin
            state <= S_RD;
          end else if (cur_cnt == '0) begin
            state <= S_WRITE;
          end else if (rseq <= nseq[cid]) begin
            res_st <= ST_NOT_INCR; state <= S_OUT;
          end else if (cmp_lt) begin
            res_st <= ST_TOO_OLD; state <= S_OUT;
          end else begin
            state <= S_CHK2;
          end
        end
        S_CHK2: begin
          if (cmp_lt) begin
            res_st <= ST_TOO_AHEAD; state <= S_OUT;
          end else begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (cur_cnt == NW'(QUEUE_DEPTH)) begin
            head[cid] <= wrap_add(cur_head, NW'(1));
          end else begin
            cnt[cid] <= cur_cnt + NW'(1);
          end
          nseq[cid] <= rseq;
          ntim[cid] <= rctime;
          state <= S_TRIM;
        end
        S_TRIM: begin
          if (cur_cnt > eff_cap) begin
            head[cid] <= wrap_add(cur_head, NW'(1));
            cnt[cid]  <= cur_cnt - NW'(1);
          end else begin
            res_st <= ST_DONE; state <= S_OUT;
          end
        end
        S_RD: begin
          // address presented, data next cycle
          if (act == ACT_REPLAY) begin
            if (idx >= cur_cnt) begin
              res_st <= found ? ST_DONE : ST_EMPTY;
              state <= found ? S_IDLE : S_OUT;
              if (found) begin
                done <= 1'b1; last_result <= 1'b1; status <= ST_ENTRY;
                out_client_id <= cid_raw;
                out_sequence <= held.seq; out_client_time_ms <= held.ctime;
                out_server_time_ms <= held.stime; out_payload <= held.payload;
              end
            end else begin
              state <= S_EVAL;
            end
          end else if (cur_cnt == '0) begin
            state <= (act == ACT_PRUNE) ? S_NEXTC : S_OUT;
          end else begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (act == ACT_REPLAY) begin
            // hold one entry back so the last one can carry last_result
            if (!cmp_lt) begin
              if (found) begin
                done <= 1'b1; last_result <= 1'b0; status <= ST_ENTRY;
                out_client_id <= cid_raw;
                out_sequence <= held.seq; out_client_time_ms <= held.ctime;
                out_server_time_ms <= held.stime; out_payload <= held.payload;
              end
              found <= 1'b1;
              held <= mrdata;
            end
            idx <= idx + NW'(1);
            state <= S_RD;
          end else begin
            // ack: seq<=rseq means !(rseq < seq); prune: stime+win < now
            if ((act == ACT_ACK) ? !cmp_lt : cmp_lt) begin
              head[cid] <= wrap_add(cur_head, NW'(1));
              cnt[cid]  <= cur_cnt - NW'(1);
              state <= S_RD;
            end else begin
              state <= (act == ACT_PRUNE) ? S_NEXTC : S_OUT;
            end
          end
        end
        S_NEXTC: begin
          if (32'(cid) == NUM_CLIENTS - 1) begin
            cid_raw <= 4'd0; state <= S_OUT;
          end else begin
            cid <= cid + CW'(1); state <= S_RD;
          end
        end
        S_OUT: begin
          done <= 1'b1; last_result <= 1'b1; status <= res_st;
          out_client_id <= cid_raw;
          out_sequence <= '0; out_client_time_ms <= '0;
          out_server_time_ms <= '0; out_payload <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt[cid] <= NW'(QUEUE_DEPTH)) else $error("queue count above depth");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (done && last_result) |=> !done) else $error("result after last");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (done && last_result) |-> (state == S_IDLE)) else $error("last result while busy");
  a_write_push: assert property (@(posedge clk) disable iff (rst)
    mwe |-> (act == ACT_PUSH) && cid_ok) else $error("write outside push");
endmodule
